// ===== hw/rtl/umtx_pkg.sv =====
`timescale 1ns / 1ps
// Package for the USB-MIDI transmit packet queue: payload types, status
// byte codes, code index values and register indexes. No dependencies.
`default_nettype none

package umtx_pkg;

    // One USB-MIDI event packet, laid out as it is kept in the queue memory.
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } pkt_t;

    localparam int PKT_W = $bits(pkt_t);

    // Input transfer payload.
    typedef struct packed {
        logic       req_type;
        logic [7:0] msg_status;
        logic [7:0] msg_data1;
        logic [7:0] msg_data2;
        logic [1:0] msg_length;
        logic       usb_ready;
    } req_t;

    // Result transfer payload.
    typedef struct packed {
        logic        packet_valid;
        logic [7:0]  packet_header;
        logic [7:0]  packet_byte1;
        logic [7:0]  packet_byte2;
        logic [7:0]  packet_byte3;
        logic        last_in_run;
        logic [7:0]  queue_level;
        logic [7:0]  queue_high_water;
        logic [15:0] overflow_drops;
    } res_t;

    // Status of the result buffer, seen by the drain control.
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } buf_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } q_state_t;

    // Request types.
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] REG_CABLE       = 1'b0;
    localparam logic [0:0] REG_DROP_OLDEST = 1'b1;

    // High nibbles of channel voice status bytes.
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_POLY_PRES = 4'hA;
    localparam logic [3:0] HI_CONTROL   = 4'hB;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_CHAN_PRES = 4'hD;
    localparam logic [3:0] HI_PITCH     = 4'hE;

    // System status bytes.
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_REALTIME_LO = 8'hF8;

    // Code index values.
    localparam logic [3:0] CIN_SYS_TWO    = 4'h2;
    localparam logic [3:0] CIN_SYS_THREE  = 4'h3;
    localparam logic [3:0] CIN_SINGLE     = 4'hF;

    // Message lengths.
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_THREE = 2'd3;

endpackage : umtx_pkg

`default_nettype wire

// ===== hw/rtl/umtx_req_if.sv =====
`timescale 1ns / 1ps
// Input channel of the USB-MIDI transmit queue: valid/ready with a request.
// Depends on umtx_pkg.
`default_nettype none

interface umtx_req_if;
    logic              valid;
    logic              ready;
    umtx_pkg::req_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface : umtx_req_if

`default_nettype wire

// ===== hw/rtl/umtx_res_if.sv =====
`timescale 1ns / 1ps
// Result channel of the USB-MIDI transmit queue: valid/ready with a result.
// Depends on umtx_pkg.
`default_nettype none

interface umtx_res_if;
    logic              valid;
    logic              ready;
    umtx_pkg::res_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface : umtx_res_if

`default_nettype wire

// ===== hw/rtl/umtx_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module umtx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : umtx_ram

`default_nettype wire

// ===== hw/rtl/umtx_encoder.sv =====
`timescale 1ns / 1ps
// Packs one MIDI message into a USB-MIDI event packet (header and three bytes).
// Depends on umtx_pkg.
`default_nettype none

module umtx_encoder (
    input  wire logic [3:0]     cable,
    input  wire logic [7:0]     msg_status,
    input  wire logic [7:0]     msg_data1,
    input  wire logic [7:0]     msg_data2,
    input  wire logic [1:0]     msg_length,
    output umtx_pkg::pkt_t      pkt
);

    logic [3:0] hi;
    logic       len3;
    logic       len2;

    assign hi   = msg_status[7:4];
    assign len3 = (msg_length == umtx_pkg::LEN_THREE);
    assign len2 = msg_length[1];

    always_comb
    begin
        pkt.header[7:4] = cable;
        pkt.header[3:0] = umtx_pkg::CIN_SINGLE;
        pkt.byte1       = msg_status;
        pkt.byte2       = 8'h00;
        pkt.byte3       = 8'h00;
        if ((hi inside {umtx_pkg::HI_NOTE_OFF, umtx_pkg::HI_NOTE_ON,
                        umtx_pkg::HI_POLY_PRES, umtx_pkg::HI_CONTROL,
                        umtx_pkg::HI_PITCH}) && len3)
        begin
            pkt.header[3:0] = hi;
            pkt.byte2       = msg_data1;
            pkt.byte3       = msg_data2;
        end
        else if ((hi inside {umtx_pkg::HI_PROGRAM, umtx_pkg::HI_CHAN_PRES}) && len2)
        begin
            pkt.header[3:0] = hi;
            pkt.byte2       = msg_data1;
        end
        else if ((msg_status inside {umtx_pkg::ST_TIME_CODE, umtx_pkg::ST_SONG_SEL})
                 && len2)
        begin
            pkt.header[3:0] = umtx_pkg::CIN_SYS_TWO;
            pkt.byte2       = msg_data1;
        end
        else if ((msg_status == umtx_pkg::ST_SONG_POS) && len3)
        begin
            pkt.header[3:0] = umtx_pkg::CIN_SYS_THREE;
            pkt.byte2       = msg_data1;
            pkt.byte3       = msg_data2;
        end
        else if ((msg_status == umtx_pkg::ST_TUNE_REQ)
                 || (msg_status >= umtx_pkg::ST_REALTIME_LO))
        begin
            // Single-byte system message: only the status byte is sent.
        end
        else
        begin
            // Unknown or short message: send the bytes the length covers.
            pkt.byte1 = (msg_length != umtx_pkg::LEN_NONE) ? msg_status : 8'h00;
            pkt.byte2 = len2 ? msg_data1 : 8'h00;
            pkt.byte3 = len3 ? msg_data2 : 8'h00;
        end
    end

endmodule : umtx_encoder

`default_nettype wire

// ===== hw/rtl/umtx_out_buf.sv =====
`timescale 1ns / 1ps
// Two-entry result buffer that drives the result channel.
// Depends on umtx_pkg and umtx_res_if.
`default_nettype none

module umtx_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire umtx_pkg::res_t     push_data,
    output umtx_pkg::buf_status_t   status,
    umtx_res_if.source              res
);

    umtx_pkg::res_t entry_reg [2];
    logic           head_reg;
    logic           head_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           pop;
    logic           tail;

    assign pop  = res.valid && res.ready;
    // With a full buffer a push is only made while the head leaves, so the
    // freed head slot takes the new entry.
    assign tail = head_reg ^ count_reg[0];

    assign head_next  = head_reg ^ pop;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    assign res.valid   = (count_reg != 2'd0);
    assign res.payload = entry_reg[head_reg];

    assign status.count = count_reg;
    assign status.pop   = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_data;
        end
    end

endmodule : umtx_out_buf

`default_nettype wire

// ===== hw/rtl/usb_midi_tx_packet_queue.sv =====
`timescale 1ns / 1ps
// Top level of the USB-MIDI transmit packet queue: encoder, queue memory,
// drain control and result buffer. Depends on umtx_pkg, umtx_req_if,
// umtx_res_if, umtx_ram, umtx_encoder and umtx_out_buf.
//
//  Channel  Direction  Handshake           Carries
//  req      in         valid/ready         send or poll request, message, link state
//  res      out        valid/ready         one packet or an empty result per transfer
//  cfg      in         cfg_we (no ready)   cable number, drop-oldest mode
//
// In the transfer cycle of a request the packet is encoded, written to the
// queue memory if it must wait, and all counters jump to their values after
// the step. A step that drains nothing leaves the drain control idle, so the
// input is ready again once the result buffer has room. A drain reads one
// queued packet per cycle from the memory while the result buffer has room,
// a rate set by its single read port, and holds the input until the last
// read is done. Reset clears the pointers, levels, drop counter and
// registers; the memory itself is not cleared, since an entry is never read
// before it is written. A stalled result channel backs up into the
// two-entry result buffer and pauses the reads.
`default_nettype none

module usb_midi_tx_packet_queue #(
    parameter int QUEUE_DEPTH = 128,
    parameter int BURST_MAX   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [3:0] cfg_wdata,
    umtx_req_if.sink        req,
    umtx_res_if.source      res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BW    = $clog2(BURST_MAX + 1);
    localparam int MW    = (CNT_W > BW) ? CNT_W : BW;

    // Configuration registers.
    logic [3:0] cable_reg;
    logic       drop_oldest_reg;

    // Queue state.
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] peak_reg;
    logic [CNT_W-1:0] peak_next;
    logic [15:0]      drop_reg;
    logic [15:0]      drop_next;

    // Drain control.
    umtx_pkg::q_state_t state_reg;
    umtx_pkg::q_state_t state_next;
    logic [BW-1:0]      remain_reg;
    logic [BW-1:0]      remain_next;
    logic               rd_pending_reg;
    logic               last_pending_reg;
    logic               last_pending_next;

    // Step decode.
    umtx_pkg::pkt_t      enc_pkt;
    umtx_pkg::pkt_t      rd_pkt;
    logic [umtx_pkg::PKT_W-1:0] ram_rdata;
    logic                accept;
    logic                is_send;
    logic                immediate;
    logic                do_push;
    logic                full;
    logic                ram_we;
    logic                issue;
    logic [CNT_W-1:0]    fill_push;
    logic [PTR_W-1:0]    rptr_push;
    logic [MW-1:0]       drain_mw;
    logic [BW-1:0]       drain_n;
    logic                buf_push;
    umtx_pkg::res_t      buf_data;
    umtx_pkg::buf_status_t buf_stat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // ---------------------------------------------------------------------
    // Configuration writes.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cable_reg       <= 4'h0;
            drop_oldest_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                umtx_pkg::REG_CABLE:       cable_reg       <= cfg_wdata;
                umtx_pkg::REG_DROP_OLDEST: drop_oldest_reg <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Encoder.
    // ---------------------------------------------------------------------
    umtx_encoder u_encoder (
        .cable      (cable_reg),
        .msg_status (req.payload.msg_status),
        .msg_data1  (req.payload.msg_data1),
        .msg_data2  (req.payload.msg_data2),
        .msg_length (req.payload.msg_length),
        .pkt        (enc_pkt)
    );

    // ---------------------------------------------------------------------
    // Step decode: the whole effect of a request on the queue is worked
    // out in the transfer cycle. Only the packet reads are left for later.
    // ---------------------------------------------------------------------
    assign accept    = req.valid && req.ready;
    assign is_send   = (req.payload.req_type == umtx_pkg::REQ_SEND);
    assign immediate = is_send && req.payload.usb_ready && (fill_reg == '0);
    assign do_push   = accept && is_send && !immediate;
    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        fill_push = fill_reg;
        rptr_push = rptr_reg;
        wptr_next = wptr_reg;
        drop_next = drop_reg;
        ram_we    = 1'b0;
        if (do_push)
        begin
            if (full)
            begin
                if (drop_reg != 16'hFFFF)
                begin
                    drop_next = drop_reg + 16'd1;
                end
                // Drop-oldest mode frees the head entry; the level is unchanged.
                if (drop_oldest_reg)
                begin
                    rptr_push = ptr_inc(rptr_reg);
                    ram_we    = 1'b1;
                    wptr_next = ptr_inc(wptr_reg);
                end
            end
            else
            begin
                ram_we    = 1'b1;
                wptr_next = ptr_inc(wptr_reg);
                fill_push = fill_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        drain_mw = '0;
        if (req.payload.usb_ready && !immediate)
        begin
            drain_mw = (MW'(fill_push) > MW'(BURST_MAX)) ? MW'(BURST_MAX) : MW'(fill_push);
        end
    end

    assign drain_n = drain_mw[BW-1:0];

    // Read issue: a read may start only if its data will find room in the
    // result buffer in the next cycle, even if nothing leaves then.
    assign issue = (state_reg == umtx_pkg::ST_DRAIN) && (remain_reg != '0)
                   && ((3'(buf_stat.count) + 3'(rd_pending_reg)) <= (3'd1 + 3'(buf_stat.pop)));

    always_comb
    begin
        fill_next         = fill_reg;
        peak_next         = peak_reg;
        rptr_next         = rptr_reg;
        remain_next       = remain_reg;
        last_pending_next = last_pending_reg;
        if (accept)
        begin
            fill_next   = fill_push - CNT_W'(drain_mw);
            peak_next   = (fill_push > peak_reg) ? fill_push : peak_reg;
            rptr_next   = rptr_push;
            remain_next = drain_n;
        end
        else if (issue)
        begin
            rptr_next         = ptr_inc(rptr_reg);
            remain_next       = remain_reg - BW'(1);
            last_pending_next = (remain_reg == BW'(1));
        end
    end

    // ---------------------------------------------------------------------
    // Drain state machine.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            umtx_pkg::ST_IDLE:
            begin
                if (accept && (drain_n != '0))
                begin
                    state_next = umtx_pkg::ST_DRAIN;
                end
            end
            umtx_pkg::ST_DRAIN:
            begin
                if ((remain_reg == '0) && !rd_pending_reg)
                begin
                    state_next = umtx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = umtx_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        case (state_reg)
            umtx_pkg::ST_IDLE:  req.ready = (buf_stat.count != 2'd2);
            umtx_pkg::ST_DRAIN: req.ready = 1'b0;
            default:            req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= umtx_pkg::ST_IDLE;
            wptr_reg         <= '0;
            rptr_reg         <= '0;
            fill_reg         <= '0;
            peak_reg         <= '0;
            drop_reg         <= '0;
            remain_reg       <= '0;
            rd_pending_reg   <= 1'b0;
            last_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wptr_reg         <= wptr_next;
            rptr_reg         <= rptr_next;
            fill_reg         <= fill_next;
            peak_reg         <= peak_next;
            drop_reg         <= drop_next;
            remain_reg       <= remain_next;
            rd_pending_reg   <= issue;
            last_pending_reg <= last_pending_next;
        end
    end

    // ---------------------------------------------------------------------
    // Queue memory. A packet written in the transfer cycle is read at the
    // earliest in the next cycle, so the read always sees the new data.
    // ---------------------------------------------------------------------
    umtx_ram #(
        .WIDTH (umtx_pkg::PKT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (enc_pkt),
        .re    (issue),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_pkt = umtx_pkg::pkt_t'(ram_rdata);

    // ---------------------------------------------------------------------
    // Result assembly. A step that sends at once or sends nothing gives its
    // one result in the transfer cycle; drained packets arrive from the
    // memory. The level fields always carry the values after the step.
    // ---------------------------------------------------------------------
    always_comb
    begin
        buf_push = 1'b0;
        buf_data = '0;
        if (rd_pending_reg)
        begin
            buf_push                  = 1'b1;
            buf_data.packet_valid     = 1'b1;
            buf_data.packet_header    = rd_pkt.header;
            buf_data.packet_byte1     = rd_pkt.byte1;
            buf_data.packet_byte2     = rd_pkt.byte2;
            buf_data.packet_byte3     = rd_pkt.byte3;
            buf_data.last_in_run      = last_pending_reg;
            buf_data.queue_level      = 8'(fill_reg);
            buf_data.queue_high_water = 8'(peak_reg);
            buf_data.overflow_drops   = drop_reg;
        end
        else if (accept && (immediate || (drain_n == '0)))
        begin
            buf_push                  = 1'b1;
            buf_data.packet_valid     = immediate;
            if (immediate)
            begin
                buf_data.packet_header = enc_pkt.header;
                buf_data.packet_byte1  = enc_pkt.byte1;
                buf_data.packet_byte2  = enc_pkt.byte2;
                buf_data.packet_byte3  = enc_pkt.byte3;
            end
            buf_data.last_in_run      = 1'b1;
            buf_data.queue_level      = 8'(fill_next);
            buf_data.queue_high_water = 8'(peak_next);
            buf_data.overflow_drops   = drop_next;
        end
    end

    umtx_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .push_data (buf_data),
        .status    (buf_stat),
        .res       (res)
    );

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // Data coming back from the memory always finds room in the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> ((buf_stat.count != 2'd2) || buf_stat.pop))
    else $error("read data returned into a full result buffer");

    // A new request is never taken while a drain is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!rd_pending_reg && (remain_reg == '0)))
    else $error("request taken during a drain");

    // The level never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

    // The drop counter saturates and never goes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (drop_reg >= $past(drop_reg)))
    else $error("drop counter decreased");

endmodule : usb_midi_tx_packet_queue

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for usb_midi_tx_packet_queue. It depends on umtx_pkg, the
// umtx_req_if and umtx_res_if channel interfaces, and the block's RTL.

module tb;

    localparam int QDEPTH = 128;
    localparam int BURST  = 16;

    // Status high nibbles that take the three-byte channel voice encoding.
    localparam logic [3:0] VOICE_HI [5] = '{umtx_pkg::HI_NOTE_OFF, umtx_pkg::HI_NOTE_ON,
                                            umtx_pkg::HI_POLY_PRES, umtx_pkg::HI_CONTROL,
                                            umtx_pkg::HI_PITCH};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [3:0] cfg_wdata;

    umtx_req_if req_ch ();
    umtx_res_if res_ch ();

    usb_midi_tx_packet_queue #(
        .QUEUE_DEPTH (QDEPTH),
        .BURST_MAX   (BURST)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .res       (res_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the block's state: register copies, the packet ring and its
    // pointers, and the level, peak and drop counters.
    logic [3:0]     cable_reg       = '0;
    logic           drop_oldest_reg = 1'b0;
    umtx_pkg::pkt_t ring_mem [QDEPTH];
    int             wr_ptr   = 0;
    int             rd_ptr   = 0;
    int             fill_lvl = 0;
    int             peak_lvl = 0;
    logic [15:0]    drop_cnt = '0;

    // Requests waiting to be offered, and results the block still owes.
    umtx_pkg::req_t msg_backlog [$];
    umtx_pkg::res_t owed_results [$];

    int             fail_count = 0;
    umtx_pkg::res_t want;
    umtx_pkg::res_t got;

    // Sender burst/gap state and receiver stall pattern.
    int          burst_left = 4;
    int          gap_left   = 0;
    logic [15:0] stall_pat  = 16'hFFFF;
    int          pat_pos    = 0;
    int          pat_life   = 64;

    // Packs one MIDI message into a USB-MIDI event packet. Messages too short
    // for their status, and unknown statuses, fall back to the single-byte
    // code with the bytes beyond the length forced to zero.
    function automatic umtx_pkg::pkt_t encode_event(input umtx_pkg::req_t r);
        umtx_pkg::pkt_t p;
        logic [3:0]     hi;
        hi = r.msg_status[7:4];
        p = '0;
        p.header[7:4] = cable_reg;
        p.byte1 = r.msg_status;
        if (hi inside {VOICE_HI[0], VOICE_HI[1], VOICE_HI[2], VOICE_HI[3], VOICE_HI[4]}
            && r.msg_length == umtx_pkg::LEN_THREE)
        begin
            p.header[3:0] = hi;
            p.byte2 = r.msg_data1;
            p.byte3 = r.msg_data2;
        end
        else if ((hi == umtx_pkg::HI_PROGRAM || hi == umtx_pkg::HI_CHAN_PRES)
                 && r.msg_length >= 2'd2)
        begin
            p.header[3:0] = hi;
            p.byte2 = r.msg_data1;
        end
        else if ((r.msg_status == umtx_pkg::ST_TIME_CODE
                  || r.msg_status == umtx_pkg::ST_SONG_SEL)
                 && r.msg_length >= 2'd2)
        begin
            p.header[3:0] = umtx_pkg::CIN_SYS_TWO;
            p.byte2 = r.msg_data1;
        end
        else if (r.msg_status == umtx_pkg::ST_SONG_POS
                 && r.msg_length == umtx_pkg::LEN_THREE)
        begin
            p.header[3:0] = umtx_pkg::CIN_SYS_THREE;
            p.byte2 = r.msg_data1;
            p.byte3 = r.msg_data2;
        end
        else if (r.msg_status == umtx_pkg::ST_TUNE_REQ
                 || r.msg_status >= umtx_pkg::ST_REALTIME_LO)
        begin
            // Tune request and realtime bytes stand alone, whatever the length.
            p.header[3:0] = umtx_pkg::CIN_SINGLE;
        end
        else
        begin
            p.header[3:0] = umtx_pkg::CIN_SINGLE;
            if (r.msg_length == umtx_pkg::LEN_NONE)
                p.byte1 = '0;
            if (r.msg_length >= 2'd2)
                p.byte2 = r.msg_data1;
            if (r.msg_length == umtx_pkg::LEN_THREE)
                p.byte3 = r.msg_data2;
        end
        return p;
    endfunction

    // Advances the shadow queue by one accepted request and appends the
    // results it causes. Every result of a step carries the levels and the
    // drop count as they stand after the whole step.
    task automatic queue_step(input umtx_pkg::req_t r);
        umtx_pkg::pkt_t sent [$];
        umtx_pkg::pkt_t p;
        umtx_pkg::res_t res;
        logic           drain_now;
        logic           idle_step;
        drain_now = 1'b0;
        idle_step = 1'b0;
        p = encode_event(r);
        if (r.req_type == umtx_pkg::REQ_SEND)
        begin
            if (r.usb_ready && fill_lvl == 0)
            begin
                sent.push_back(p);
            end
            else
            begin
                if (fill_lvl >= QDEPTH)
                begin
                    if (drop_cnt != 16'hFFFF)
                        drop_cnt++;
                    if (drop_oldest_reg)
                    begin
                        rd_ptr = (rd_ptr + 1) % QDEPTH;
                        fill_lvl--;
                    end
                end
                if (fill_lvl < QDEPTH)
                begin
                    ring_mem[wr_ptr] = p;
                    wr_ptr = (wr_ptr + 1) % QDEPTH;
                    fill_lvl++;
                    if (fill_lvl > peak_lvl)
                        peak_lvl = fill_lvl;
                end
                drain_now = r.usb_ready;
            end
        end
        else
        begin
            drain_now = r.usb_ready;
        end
        while (drain_now && sent.size() < BURST && fill_lvl > 0)
        begin
            sent.push_back(ring_mem[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % QDEPTH;
            fill_lvl--;
        end
        // Nothing went out on the link: one empty result still closes the step.
        if (sent.size() == 0)
        begin
            sent.push_back('0);
            idle_step = 1'b1;
        end
        foreach (sent[i])
        begin
            res = '0;
            res.packet_valid     = !idle_step;
            res.packet_header    = sent[i].header;
            res.packet_byte1     = sent[i].byte1;
            res.packet_byte2     = sent[i].byte2;
            res.packet_byte3     = sent[i].byte3;
            res.last_in_run      = (i == sent.size() - 1);
            res.queue_level      = 8'(fill_lvl);
            res.queue_high_water = 8'(peak_lvl);
            res.overflow_drops   = drop_cnt;
            owed_results.push_back(res);
        end
    endtask

    function automatic umtx_pkg::req_t make_req(input logic rt, input logic [7:0] s,
                                                input logic [7:0] d1, input logic [7:0] d2,
                                                input logic [1:0] len, input logic rdy);
        umtx_pkg::req_t r;
        r.req_type   = rt;
        r.msg_status = s;
        r.msg_data1  = d1;
        r.msg_data2  = d2;
        r.msg_length = len;
        r.usb_ready  = rdy;
        return r;
    endfunction

    // Random message, mostly well formed for its status, with some noise.
    function automatic umtx_pkg::req_t random_msg(input logic rt, input logic rdy);
        umtx_pkg::req_t r;
        int             kind;
        kind = $urandom_range(0, 9);
        r = make_req(rt, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), rdy);
        case (kind)
            0, 1, 2, 3:
            begin
                r.msg_status[7:4] = VOICE_HI[$urandom_range(0, 4)];
                r.msg_length = umtx_pkg::LEN_THREE;
            end
            4:
            begin
                r.msg_status[7:4] = $urandom_range(0, 1) ? umtx_pkg::HI_PROGRAM
                                                         : umtx_pkg::HI_CHAN_PRES;
                r.msg_length = 2'($urandom_range(2, 3));
            end
            5:
            begin
                r.msg_status = $urandom_range(0, 1) ? umtx_pkg::ST_TIME_CODE
                                                    : umtx_pkg::ST_SONG_SEL;
                r.msg_length = 2'($urandom_range(2, 3));
            end
            6:
            begin
                r.msg_status = umtx_pkg::ST_SONG_POS;
                r.msg_length = umtx_pkg::LEN_THREE;
            end
            7:
            begin
                r.msg_status = $urandom_range(0, 1) ? umtx_pkg::ST_TUNE_REQ
                                                    : 8'($urandom_range(8'hF8, 8'hFF));
            end
            default:
            begin
                // Noise: any status byte with any length.
            end
        endcase
        return r;
    endfunction

    function automatic umtx_pkg::req_t random_req(input int ready_pct);
        return random_msg(($urandom_range(0, 3) == 0) ? umtx_pkg::REQ_POLL
                                                      : umtx_pkg::REQ_SEND,
                          $urandom_range(0, 99) < ready_pct);
    endfunction

    task automatic flag_fail(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", what);
    endtask

    function automatic string show_res(input umtx_pkg::res_t r);
        return $sformatf("vld=%0d hdr=%h b=%h %h %h last=%0d lvl=%0d hw=%0d drops=%0d",
                         r.packet_valid, r.packet_header, r.packet_byte1, r.packet_byte2,
                         r.packet_byte3, r.last_in_run, r.queue_level,
                         r.queue_high_water, r.overflow_drops);
    endfunction

    // The shadow copy of a register follows each write at once.
    task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == umtx_pkg::REG_CABLE)
            cable_reg = val;
        else
            drop_oldest_reg = val[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sampled at the falling edge so that every update of the rising edge is in.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (msg_backlog.size() != 0 || req_ch.valid || owed_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Request driver: offers backlog items in bursts of random length with
    // random gaps between them. The shadow queue advances on each transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                queue_step(req_ch.payload);
            if (req_ch.valid && !req_ch.ready)
            begin
                // The offered request stays on the channel until it is taken.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (msg_backlog.size() > 0)
            begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= msg_backlog.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready follows a rotating 16-bit pattern that is
    // replaced when its random life runs out. Bit 0 is always set, so every
    // stall ends before the pattern comes round again; some patterns never stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= stall_pat[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
            pat_life--;
            if (pat_life <= 0)
            begin
                pat_life = $urandom_range(32, 160);
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom) | 16'h0001;
                    2: stall_pat = 16'($urandom | $urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
        end
    end

    // Result checker: each transfer is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.payload;
            if (owed_results.size() == 0)
            begin
                flag_fail({"result with nothing owed: ", show_res(got)});
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.packet_valid !== want.packet_valid
                    || got.packet_header !== want.packet_header
                    || got.packet_byte1 !== want.packet_byte1
                    || got.packet_byte2 !== want.packet_byte2
                    || got.packet_byte3 !== want.packet_byte3
                    || got.last_in_run !== want.last_in_run
                    || got.queue_level !== want.queue_level
                    || got.queue_high_water !== want.queue_high_water
                    || got.overflow_drops !== want.overflow_drops)
                    flag_fail({"expected ", show_res(want), " got ", show_res(got)});
            end
        end
    end

    // Stimulus. After reset, both registers are written, then a directed
    // pass covers every encoding and the empty-result cases. The ring is then
    // filled past full with the link down (new packets dropped), the mode is
    // switched to drop the oldest entry while the ring is still full, and two
    // random phases mix sends and polls with the link up and down.
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = umtx_pkg::REG_CABLE;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        res_ch.ready   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(umtx_pkg::REG_CABLE, 4'h0);
        write_reg(umtx_pkg::REG_DROP_OLDEST, 4'h0);

        // Every encoding with the link up and the ring empty, so each goes out
        // at once.
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h90, 8'h3C, 8'h7F, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h80, 8'h00, 8'h00, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hA5, 8'hFF, 8'h80, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hB0, 8'h07, 8'h64, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hEF, 8'h7F, 8'h7F, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hC3, 8'h05, 8'hAA, 2'd2, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hD0, 8'h40, 8'h55, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF1, 8'h12, 8'h34, 2'd2, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF3, 8'h01, 8'h02, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF2, 8'h10, 8'h20, 2'd3, 1'b1));
        // Tune request with zero length still encodes as a single byte.
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF6, 8'h11, 8'h22, 2'd0, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF8, 8'h33, 8'h44, 2'd1, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
        // Short, zero-length and unknown messages fall back to the single-byte code.
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h90, 8'h3C, 8'h7F, 2'd2, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h92, 8'h55, 8'h66, 2'd0, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hC1, 8'h00, 8'h00, 2'd1, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF2, 8'h01, 8'h02, 2'd2, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h7F, 8'h01, 8'h02, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF4, 8'hAA, 8'hBB, 2'd3, 1'b1));
        // Polls on an empty ring and with the link down give an empty result.
        msg_backlog.push_back(make_req(umtx_pkg::REQ_POLL, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_POLL, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b0));
        // Queue three with the link down, then a ready send drains all four.
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'h9A, 8'h01, 8'h02, 2'd3, 1'b0));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF0, 8'h03, 8'h04, 2'd2, 1'b0));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hF1, 8'h7F, 8'h00, 2'd1, 1'b0));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_SEND, 8'hE3, 8'h11, 8'h22, 2'd3, 1'b1));
        msg_backlog.push_back(make_req(umtx_pkg::REQ_POLL, 8'h5A, 8'hA5, 8'h3C, 2'd2, 1'b1));
        wait_drained();

        // Fill past full with the link down; the newest packets are lost.
        write_reg(umtx_pkg::REG_CABLE, 4'hF);
        for (int i = 0; i < QDEPTH + 3; i++)
            msg_backlog.push_back(random_msg(umtx_pkg::REQ_SEND, 1'b0));
        wait_drained();

        // Still full: now the oldest entries make room, then a ready send
        // drains a full burst and random traffic follows.
        write_reg(umtx_pkg::REG_DROP_OLDEST, 4'h1);
        write_reg(umtx_pkg::REG_CABLE, 4'hA);
        for (int i = 0; i < 5; i++)
            msg_backlog.push_back(random_msg(umtx_pkg::REQ_SEND, 1'b0));
        msg_backlog.push_back(random_msg(umtx_pkg::REQ_SEND, 1'b1));
        for (int i = 0; i < 75; i++)
            msg_backlog.push_back(random_req(30));
        wait_drained();

        write_reg(umtx_pkg::REG_DROP_OLDEST, 4'h0);
        write_reg(umtx_pkg::REG_CABLE, 4'($urandom_range(1, 14)));
        for (int i = 0; i < 70; i++)
            msg_backlog.push_back(random_req(60));
        wait_drained();

        // Give the block time to show any result it should not produce.
        repeat (40) @(posedge clk);
        if (owed_results.size() != 0)
            flag_fail($sformatf("%0d results never arrived", owed_results.size()));

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit: several times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
